// ===== sv/lzw_enc_pkg.sv =====
`timescale 1ns / 1ps

package lzw_enc_pkg;

  localparam int DICT_SIZE_DEF = 4096;
  localparam int BYTE_CODES    = 256;
  localparam int BYTE_W        = 8;
  localparam int CODE_W        = 12;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 16;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take the input item, restart the search pointer
    logic search;    // step the dictionary scan
    logic take_hit;  // prefix becomes the matching code
    logic emit;      // output prefix code, learn prefix+byte while the table has room, restart from byte
    logic flush;     // output final prefix code, clear stream state
  } lzw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic prefix_valid;
    logic last;
    logic hit;
    logic miss;
    logic out_free;
  } lzw_sts_t;

endpackage

// ===== sv/lzw_enc_ctrl.sv =====
`timescale 1ns / 1ps

module lzw_enc_ctrl
  import lzw_enc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  lzw_sts_t sts_i,
  output lzw_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;
  localparam logic [1:0] StLast   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.prefix_valid) begin
            state_d = in_last_i ? StLast : StIdle;
          end else begin
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d = sts_i.last ? StLast : StIdle;
        end else if (sts_i.miss) begin
          state_d = StEmit;
        end else begin
          cmd_o.search = 1'b1;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.last ? StLast : StIdle;
        end
      end
      StLast: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/lzw_enc_dpath.sv =====
`timescale 1ns / 1ps

module lzw_enc_dpath
  import lzw_enc_pkg::*;
#(
  parameter int DICT_SIZE = DICT_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  input  lzw_cmd_t          cmd_i,
  output lzw_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] out_code_o,
  output logic              out_last_o
);

  localparam int CW    = $clog2(DICT_SIZE);
  localparam int EW    = CW + BYTE_W;
  localparam int DEPTH = DICT_SIZE - BYTE_CODES;
  localparam int SW    = $clog2(DEPTH);
  localparam logic [CW:0] BaseCode = (CW+1)'(BYTE_CODES);
  localparam logic [CW:0] DictLim  = (CW+1)'(DICT_SIZE);

  logic [EW-1:0] mem [DEPTH];

  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [CW-1:0]     prefix_q;
  logic              pvalid_q;
  logic [CW:0]       next_q;
  logic [CW:0]       rd_code_q;
  logic [CW-1:0]     cmp_code_q;
  logic              rd_pend_q;
  logic [EW-1:0]     rdata_q;
  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;
  logic              out_last_q;

  logic [CW:0]        rd_off, wr_off;
  logic [SW-1:0]      rd_slot, wr_slot;
  logic               issue, hit, learn, out_free;
  logic [CW-1:0]      byte_code;
  logic [CW+CODE_W-1:0] code_ext;

  assign rd_off    = rd_code_q - BaseCode;
  assign wr_off    = next_q - BaseCode;
  assign rd_slot   = rd_off[SW-1:0];
  assign wr_slot   = wr_off[SW-1:0];
  assign issue     = cmd_i.search && (rd_code_q < next_q);
  assign hit       = rd_pend_q && (rdata_q == {prefix_q, byte_q});
  assign learn     = cmd_i.emit && (next_q < DictLim);
  assign out_free  = !out_valid_q || out_ready_i;
  assign byte_code = {{(CW-BYTE_W){1'b0}}, byte_q};
  assign code_ext  = {{CODE_W{1'b0}}, prefix_q};

  assign sts_o.prefix_valid = pvalid_q;
  assign sts_o.last         = last_q;
  assign sts_o.hit          = hit;
  assign sts_o.miss         = !rd_pend_q && !(rd_code_q < next_q);
  assign sts_o.out_free     = out_free;

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

  // dictionary: one write port for learning, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (learn) begin
      mem[wr_slot] <= {prefix_q, byte_q};
    end
    if (issue) begin
      rdata_q <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (issue) begin
      cmp_code_q <= rd_code_q[CW-1:0];
    end
    if (cmd_i.emit || cmd_i.flush) begin
      out_code_q <= code_ext[CODE_W-1:0];
      out_last_q <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      pvalid_q    <= 1'b0;
      next_q      <= BaseCode;
      rd_code_q   <= BaseCode;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_code_q <= BaseCode;
        rd_pend_q <= 1'b0;
        if (!pvalid_q) begin
          prefix_q <= {{(CW-BYTE_W){1'b0}}, in_byte_i};
          pvalid_q <= 1'b1;
        end
      end else if (cmd_i.search) begin
        rd_pend_q <= issue;
        if (issue) begin
          rd_code_q <= rd_code_q + 1'b1;
        end
      end
      if (cmd_i.take_hit) begin
        prefix_q <= cmp_code_q;
      end
      if (cmd_i.emit) begin
        prefix_q <= byte_code;
        if (learn) begin
          next_q <= next_q + 1'b1;
        end
      end
      if (cmd_i.flush) begin
        prefix_q <= '0;
        pvalid_q <= 1'b0;
        next_q   <= BaseCode;
      end
      if (cmd_i.emit || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/lzw_encoder_top.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata[7:0] in_byte, tlast in_last
// m_axis   out  m_axis_tvalid/tready      tdata[11:0] out_code, tlast out_last
//
// The first byte of a stream becomes the prefix without a scan. Any other byte is
// accepted, then scanned against the learned entries (at most DICT_SIZE-256), as
// the single dictionary read port checks one entry a cycle. A miss adds an emit
// step, a final byte a flush step.
// Reset leaves the dictionary contents undefined; only learned entries are scanned.
// A stalled output holds the block in its emit or flush state until taken.

module lzw_encoder_top
  import lzw_enc_pkg::*;
#(
  parameter int DICT_SIZE = DICT_SIZE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [11:0] out_code, [15:12] zero
  output logic                   m_axis_tlast_o
);

  lzw_cmd_t          cmd;
  lzw_sts_t          sts;
  logic [CODE_W-1:0] out_code;

  lzw_enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzw_enc_dpath #(
    .DICT_SIZE (DICT_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata_i[BYTE_W-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_code_o  (out_code),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W-CODE_W){1'b0}}, out_code};

endmodule

// ===== sv/lzw_enc_checker.sv =====
`timescale 1ns / 1ps

module lzw_enc_checker
  import lzw_enc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                   s_axis_tlast_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tlast_o
);

  // a final item always leads to a flush, so no new item the next cycle
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken right after a final item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output item changed");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:CODE_W] == '0)
    else $error("output padding not zero");

  // valid may still be unknown at the very first edge; the asynchronous reset clears it
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind lzw_encoder_top lzw_enc_checker u_lzw_enc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lzw_enc_pkg::*;

  // A 512-entry dictionary keeps each table scan short
  localparam int TB_DICT   = 512;
  localparam int MAX_CYCLES = 1_500_000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } lzw_code_t;

  // Tracks the encoder's prefix and learned strings and queues the codes it must emit
  class lzw_code_tracker;
    logic [CODE_W-1:0] pfx_code   = '0;
    logic              pfx_held   = 1'b0;
    logic [12:0]       free_code  = 13'(BYTE_CODES);
    logic [CODE_W-1:0] entry_pfx  [TB_DICT-BYTE_CODES];
    logic [BYTE_W-1:0] entry_byte [TB_DICT-BYTE_CODES];
    lzw_code_t         codes_due[$];
    int mismatches  = 0;
    int checked     = 0;
    int bytes_in    = 0;
    int streams     = 0;
    int full_misses = 0;

    function void take_byte(logic [BYTE_W-1:0] b, logic last);
      logic [12:0] hit;
      hit = 13'(TB_DICT);
      bytes_in++;
      if (!pfx_held) begin
        pfx_code = {4'h0, b};
        pfx_held = 1'b1;
      end else begin
        for (int c = BYTE_CODES; c < free_code; c++) begin
          if (entry_pfx[c-BYTE_CODES] == pfx_code && entry_byte[c-BYTE_CODES] == b) begin
            hit = 13'(c);
            break;
          end
        end
        if (hit != TB_DICT) begin
          pfx_code = hit[CODE_W-1:0];
        end else begin
          codes_due.push_back('{code: pfx_code, last: 1'b0});
          if (free_code < TB_DICT) begin
            entry_pfx[free_code-BYTE_CODES]  = pfx_code;
            entry_byte[free_code-BYTE_CODES] = b;
            free_code++;
          end else begin
            full_misses++;
          end
          pfx_code = {4'h0, b};
        end
      end
      if (last) begin
        codes_due.push_back('{code: pfx_code, last: 1'b1});
        pfx_held  = 1'b0;
        pfx_code  = '0;
        free_code = 13'(BYTE_CODES);
        streams++;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_code(logic [OUT_TDATA_W-1:0] data, logic last);
      lzw_code_t want;
      if (codes_due.size() == 0) begin
        flag($sformatf("unexpected code 0x%0h last %0b", data, last));
        return;
      end
      want = codes_due.pop_front();
      checked++;
      // padding above the code must stay zero
      if (data !== {4'h0, want.code} || last !== want.last)
        flag($sformatf("code 0x%0h last %0b, expected code 0x%0h last %0b",
                       data, last, want.code, want.last));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;   // [7:0] in_byte
  logic                   s_axis_tlast_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;         // [11:0] out_code, [15:12] zero
  logic                   m_axis_tlast_o;

  lzw_code_tracker sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  lzw_encoder_top #(.DICT_SIZE(TB_DICT)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d codes still due", cycles, sb.codes_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // output side: check each accepted code, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_code(m_axis_tdata_o, m_axis_tlast_o);
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_byte(b, last);
  endtask

  // alphabet of 256 means any byte; small alphabets give long matched strings
  task automatic send_stream(input int len, input int alpha);
    logic [BYTE_W-1:0] base;
    base = BYTE_W'($urandom);
    for (int i = 0; i < len; i++)
      send_byte((alpha >= 256) ? BYTE_W'($urandom)
                               : BYTE_W'(base + $urandom_range(alpha - 1)),
                i == len - 1);
  endtask

  // hold the input until every code is out, then allow a full table scan to finish
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.codes_due.size() != 0) @(posedge clk_i);
    repeat (TB_DICT + 8) @(posedge clk_i);
  endtask

  initial begin
    int items;
    int alpha;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-byte streams: first byte becomes the prefix and is flushed at once
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // alternating extremes: learning, a hit, and a final byte that hits
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // one byte repeated: ever longer matched strings
    for (int i = 0; i < 8; i++) send_byte(8'hAA, i == 7);
    // final byte that misses gives two codes
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      items = 0;
      while (items < 25) begin
        case ($urandom_range(3))
          0: alpha = 2;
          1: alpha = 4;
          2: alpha = 16;
          default: alpha = 256;
        endcase
        len_loop: begin
          int len;
          len = $urandom_range(1, 16);
          send_stream(len, alpha);
          items += len;
        end
      end
      wait_drained();
    end

    $display("Run covered %0d streams, %0d bytes and %0d codes, with %0d misses on a full table.",
             sb.streams, sb.bytes_in, sb.checked, sb.full_misses);
    $display("Mismatches: %0d, codes left over: %0d", sb.mismatches, sb.codes_due.size());
    if (sb.mismatches == 0 && sb.codes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
